// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the MDIO frame master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that prop holds at every clock edge out of reset
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that cond never holds at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hdl/mdc22_pkg.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 package
// Types and constants shared by the frame master modules.
// ----------------------------------------------------------------------------
package mdc22_pkg;

	localparam int unsigned PRE_W = 7;
	localparam logic [PRE_W-1:0] PRE_MAX = 7'd64;
	localparam logic [PRE_W-1:0] WR_PRE_RST = 7'd32;
	localparam logic [PRE_W-1:0] RD_PRE_RST = 7'd64;

	localparam logic [5:0] WR_LAST_CLK = 6'd31;
	localparam logic [5:0] RD_LAST_CLK = 6'd32;
	localparam logic [5:0] RD_DRIVEN_CLKS = 6'd14;
	localparam logic [5:0] RD_SAMPLE_FIRST = 6'd16;
	localparam logic [5:0] RD_SAMPLE_LAST = 6'd31;
	localparam logic [PRE_W-1:0] POS_MAX = 7'd96;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic {
		REG_WR_PRE = 1'b0,
		REG_RD_PRE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  phy_addr;
		logic [4:0]  reg_addr;
		logic [15:0] write_data;
		logic        mdio_in;
	} req_t;

	typedef struct packed {
		logic        mdc;
		logic        mdio_out;
		logic        mdio_drive;
		logic        busy_res;
		logic        read_valid;
		logic [15:0] read_data;
	} rsp_t;

	typedef struct packed {
		logic [PRE_W-1:0] wr_pre;
		logic [PRE_W-1:0] rd_pre;
	} cfg_t;

endpackage

// File: hdl/mdc22_if.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface mdc22_req_if;
	logic            valid;
	logic            ready;
	mdc22_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mdc22_rsp_if;
	logic            valid;
	logic            ready;
	mdc22_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mdc22_cfg.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 configuration registers
// Preamble length registers, saturated to 64 on write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdc22_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [mdc22_pkg::PRE_W-1:0]      cfg_wdata,
	output mdc22_pkg::cfg_t                   cfg
);

	logic [mdc22_pkg::PRE_W-1:0] wr_pre_q;
	logic [mdc22_pkg::PRE_W-1:0] rd_pre_q;
	logic [mdc22_pkg::PRE_W-1:0] wval;

	assign wval = (cfg_wdata > mdc22_pkg::PRE_MAX) ? mdc22_pkg::PRE_MAX : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pre_q <= mdc22_pkg::WR_PRE_RST;
			rd_pre_q <= mdc22_pkg::RD_PRE_RST;
		end else if (cfg_we) begin
			unique case (mdc22_pkg::cfg_idx_t'(cfg_index))
				mdc22_pkg::REG_WR_PRE: wr_pre_q <= wval;
				mdc22_pkg::REG_RD_PRE: rd_pre_q <= wval;
				default: ;
			endcase
		end
	end

	assign cfg.wr_pre = wr_pre_q;
	assign cfg.rd_pre = rd_pre_q;

	`ASSERT_NEVER(a_wr_pre_sat, clk, arst_n, wr_pre_q > mdc22_pkg::PRE_MAX, "write preamble above 64")
	`ASSERT_NEVER(a_rd_pre_sat, clk, arst_n, rd_pre_q > mdc22_pkg::PRE_MAX, "read preamble above 64")

endmodule

// File: hdl/mdc22_core.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame core
// Input register, frame sequencing logic and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdc22_core (
	input  logic              clk,
	input  logic              arst_n,
	input  mdc22_pkg::cfg_t   cfg,
	mdc22_req_if.sink         req,
	mdc22_rsp_if.source       rsp
);

	// input stage
	logic            valid_s1;
	mdc22_pkg::req_t req_s1;
	logic            adv;

	// result stage
	logic            valid_s2;
	mdc22_pkg::rsp_t rsp_s2;

	// frame state
	logic        active_q;
	logic        is_read_q;
	logic [6:0]  pos_q;
	logic        half_q;
	logic [31:0] shift_q;
	logic [15:0] cap_q;

	// next values
	logic        start;
	logic        act;
	logic        is_rd;
	logic [6:0]  pos;
	logic        half;
	logic [31:0] shift;
	logic [6:0]  pre;
	logic [5:0]  last;
	logic        in_pre;
	logic [6:0]  kraw;
	logic        fin;
	logic [5:0]  kc;
	logic [4:0]  bidx;
	logic        capture;
	logic [15:0] cap_n;
	logic        active_n;
	logic [6:0]  pos_n;
	logic        half_n;
	mdc22_pkg::rsp_t res;

	assign adv = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	always_comb begin
		start = !active_q && (req_s1.operation == mdc22_pkg::OP_READ ||
			req_s1.operation == mdc22_pkg::OP_WRITE);
		act = active_q || start;
		is_rd = start ? (req_s1.operation == mdc22_pkg::OP_READ) : is_read_q;
		pos = start ? 7'd0 : pos_q;
		half = start ? 1'b0 : half_q;
		if (!start) begin
			shift = shift_q;
		end else if (is_rd) begin
			shift = {4'b0110, req_s1.phy_addr, req_s1.reg_addr, 18'd0};
		end else begin
			shift = {4'b0101, req_s1.phy_addr, req_s1.reg_addr, 2'b10, req_s1.write_data};
		end

		pre = is_rd ? cfg.rd_pre : cfg.wr_pre;
		last = is_rd ? mdc22_pkg::RD_LAST_CLK : mdc22_pkg::WR_LAST_CLK;
		in_pre = pos < pre;
		kraw = pos - pre;
		fin = !in_pre && (kraw >= {1'b0, last});
		kc = in_pre ? 6'd0 : (fin ? last : kraw[5:0]);
		bidx = 5'd31 - kc[4:0];

		res.mdc = 1'b1;
		res.mdio_out = 1'b0;
		res.mdio_drive = 1'b0;
		res.busy_res = 1'b0;
		res.read_valid = 1'b0;
		capture = 1'b0;
		active_n = active_q;
		pos_n = pos_q;
		half_n = half_q;

		if (act) begin
			res.busy_res = 1'b1;
			res.mdc = half;
			if (in_pre) begin
				res.mdio_drive = 1'b1;
				res.mdio_out = 1'b1;
			end else if (!is_rd || kc < mdc22_pkg::RD_DRIVEN_CLKS) begin
				res.mdio_drive = 1'b1;
				res.mdio_out = shift[bidx];
			end else begin
				capture = (kc >= mdc22_pkg::RD_SAMPLE_FIRST) &&
					(kc <= mdc22_pkg::RD_SAMPLE_LAST) && !half;
			end

			active_n = 1'b1;
			pos_n = pos;
			half_n = !half;
			if (half) begin
				if (fin) begin
					res.read_valid = is_rd;
					active_n = 1'b0;
					pos_n = 7'd0;
				end else begin
					pos_n = pos + 7'd1;
				end
			end
		end

		cap_n = capture ? {cap_q[14:0], req_s1.mdio_in} : cap_q;
		res.read_data = cap_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			is_read_q <= 1'b0;
			pos_q <= 7'd0;
			half_q <= 1'b0;
			shift_q <= 32'd0;
			cap_q <= 16'd0;
		end else if (adv) begin
			active_q <= active_n;
			is_read_q <= is_rd;
			pos_q <= pos_n;
			half_q <= half_n;
			shift_q <= shift;
			cap_q <= cap_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= res;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data = rsp_s2;

	`ASSERT_CHK(a_rdv_busy, clk, arst_n, valid_s2 && rsp_s2.read_valid |-> rsp_s2.busy_res, "read_valid outside a frame")
	`ASSERT_CHK(a_idle_clear, clk, arst_n, !active_q |-> (pos_q == 7'd0) && !half_q, "idle with stale position")
	`ASSERT_NEVER(a_pos_bound, clk, arst_n, pos_q > mdc22_pkg::POS_MAX, "clock index past frame end")
	`ASSERT_CHK(a_s1_hold, clk, arst_n, valid_s1 && !adv |=> valid_s1, "input stage dropped a beat")
	`ASSERT_CHK(a_rdv_end, clk, arst_n, adv && res.read_valid |=> !active_q, "frame still active after read_valid")

endmodule

// File: hdl/mdio_clause22_frame_master.sv
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame master
// Top level: configuration registers and frame core.
// ----------------------------------------------------------------------------
// Every request beat is one MDC half period and yields exactly one result beat
// with the MDC level, the MDIO drive and level, busy, read_valid and the
// capture register. A beat is accepted every cycle while results are taken;
// each beat passes through the input register and then the result register,
// with the frame state updated in the single pass between them.
// Preamble lengths are written through cfg_we/cfg_index/cfg_wdata (index 0
// write preamble, index 1 read preamble) and saturate at 64.
module mdio_clause22_frame_master (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mdc22_pkg::PRE_W-1:0]  cfg_wdata,
	mdc22_req_if.sink                     req,
	mdc22_rsp_if.source                   rsp
);

	mdc22_pkg::cfg_t cfg;

	mdc22_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mdc22_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// File: tb/sv/mdio_clause22_frame_master_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MDIO Clause 22 frame master testbench
// Drives MDC half-period beats that hold read frames, write frames and noise.
// A cycle-accurate frame predictor produces the expected result beat for every
// accepted request beat, and a monitor checks each result beat field by field.
// Preamble lengths change between phases, and only while the master is idle.
// Both channels idle at random at rates set per phase; the last two phases never stall them at random.
// ----------------------------------------------------------------------------
module mdio_clause22_frame_master_tb;

	localparam logic [3:0] ST_OP_READ = 4'b0110;
	localparam logic [3:0] ST_OP_WRITE = 4'b0101;
	localparam logic [1:0] TA_BITS = 2'b10;
	localparam int unsigned DIN_ZERO = 0;
	localparam int unsigned DIN_ONE = 1;
	localparam int unsigned DIN_RAND = 2;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [mdc22_pkg::PRE_W-1:0] cfg_wdata;

	mdc22_req_if req_ch();
	mdc22_rsp_if rsp_ch();

	mdio_clause22_frame_master i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// frame predictor state
	logic [mdc22_pkg::PRE_W-1:0] pre_wr = mdc22_pkg::WR_PRE_RST;
	logic [mdc22_pkg::PRE_W-1:0] pre_rd = mdc22_pkg::RD_PRE_RST;
	bit frm_active = 1'b0;
	bit frm_read = 1'b0;
	logic [mdc22_pkg::PRE_W-1:0] clk_pos = '0;
	bit hi_half = 1'b0;
	logic [31:0] tx_bits = '0;
	logic [15:0] rx_bits = '0;

	mdc22_pkg::req_t pending_beats[$];
	mdc22_pkg::rsp_t expected_halves[$];
	int unsigned queued_beats = 0;
	int unsigned mismatch_count = 0;
	int unsigned req_idle_pct = 0;
	int unsigned rsp_stall_pct = 0;
	bit req_taken = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic mdc22_pkg::rsp_t predict_half(mdc22_pkg::req_t beat);
		mdc22_pkg::rsp_t res;
		logic [mdc22_pkg::PRE_W-1:0] pre;
		int unsigned last_clk;
		int unsigned body_clk;
		bit in_pre;
		bit final_clk;
		mdc22_pkg::op_t op;
		op = mdc22_pkg::op_t'(beat.operation);
		if (!frm_active && (op == mdc22_pkg::OP_READ || op == mdc22_pkg::OP_WRITE)) begin
			frm_active = 1'b1;
			frm_read = (op == mdc22_pkg::OP_READ);
			clk_pos = '0;
			hi_half = 1'b0;
			if (frm_read) begin
				tx_bits = {ST_OP_READ, beat.phy_addr, beat.reg_addr, 18'd0};
			end else begin
				tx_bits = {ST_OP_WRITE, beat.phy_addr, beat.reg_addr, TA_BITS,
					beat.write_data};
			end
		end
		res = '0;
		res.mdc = 1'b1;
		if (frm_active) begin
			pre = frm_read ? pre_rd : pre_wr;
			last_clk = frm_read ? 32'(mdc22_pkg::RD_LAST_CLK) : 32'(mdc22_pkg::WR_LAST_CLK);
			in_pre = (clk_pos < pre);
			body_clk = 0;
			final_clk = 1'b0;
			if (!in_pre) begin
				body_clk = 32'(clk_pos) - 32'(pre);
				if (body_clk >= last_clk) begin
					body_clk = last_clk;
					final_clk = 1'b1;
				end
			end
			res.busy_res = 1'b1;
			res.mdc = hi_half;
			if (in_pre) begin
				res.mdio_drive = 1'b1;
				res.mdio_out = 1'b1;
			end else if (!frm_read || body_clk < 32'(mdc22_pkg::RD_DRIVEN_CLKS)) begin
				res.mdio_drive = 1'b1;
				res.mdio_out = tx_bits[31 - body_clk];
			end else if (body_clk >= 32'(mdc22_pkg::RD_SAMPLE_FIRST)
					&& body_clk <= 32'(mdc22_pkg::RD_SAMPLE_LAST) && !hi_half) begin
				rx_bits = {rx_bits[14:0], beat.mdio_in};
			end
			if (hi_half) begin
				hi_half = 1'b0;
				if (final_clk) begin
					res.read_valid = frm_read;
					frm_active = 1'b0;
					clk_pos = '0;
				end else begin
					clk_pos = clk_pos + 7'd1;
				end
			end else begin
				hi_half = 1'b1;
			end
		end
		res.read_data = rx_bits;
		return res;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_beat(mdc22_pkg::rsp_t want, mdc22_pkg::rsp_t got);
		check_field("mdc", 16'(want.mdc), 16'(got.mdc));
		check_field("mdio_out", 16'(want.mdio_out), 16'(got.mdio_out));
		check_field("mdio_drive", 16'(want.mdio_drive), 16'(got.mdio_drive));
		check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
		check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
		check_field("read_data", want.read_data, got.read_data);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = req_ch.valid && req_ch.ready;
			if (req_taken) begin
				expected_halves.push_back(predict_half(req_ch.data));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_halves.size() == 0) begin
					$error("result beat with no expected value pending");
					mismatch_count++;
				end else begin
					check_beat(expected_halves.pop_front(), rsp_ch.data);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			if (!req_ch.valid || req_taken) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
					req_ch.data <= pending_beats.pop_front();
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic push_beat(mdc22_pkg::op_t op, logic [4:0] pa, logic [4:0] ra,
			logic [15:0] wd, logic din);
		mdc22_pkg::req_t beat;
		beat.operation = op;
		beat.phy_addr = pa;
		beat.reg_addr = ra;
		beat.write_data = wd;
		beat.mdio_in = din;
		pending_beats.push_back(beat);
		queued_beats++;
	endtask

	task automatic push_tick();
		push_beat(mdc22_pkg::OP_TICK, 5'($urandom_range(31)), 5'($urandom_range(31)),
			16'($urandom_range(65535)), 1'($urandom_range(1)));
	endtask

	function automatic logic pick_din(int unsigned din_mode);
		if (din_mode == DIN_RAND) begin
			return 1'($urandom_range(1));
		end
		return (din_mode == DIN_ONE);
	endfunction

	function automatic mdc22_pkg::op_t random_op();
		return mdc22_pkg::op_t'(2'($urandom_range(3)));
	endfunction

	function automatic mdc22_pkg::op_t random_start();
		return $urandom_range(1) ? mdc22_pkg::OP_READ : mdc22_pkg::OP_WRITE;
	endfunction

	// start beat, then ticks (random ops if noisy) covering the whole frame; tail_op lands on the last half
	task automatic queue_frame(mdc22_pkg::op_t op, logic [4:0] pa, logic [4:0] ra,
			logic [15:0] wd, int unsigned din_mode, bit noisy, mdc22_pkg::op_t tail_op);
		int unsigned halves;
		mdc22_pkg::op_t tick_op;
		if (op == mdc22_pkg::OP_READ) begin
			halves = 2 * (32'(pre_rd) + 32'(mdc22_pkg::RD_LAST_CLK) + 1);
		end else begin
			halves = 2 * (32'(pre_wr) + 32'(mdc22_pkg::WR_LAST_CLK) + 1);
		end
		push_beat(op, pa, ra, wd, pick_din(din_mode));
		for (int unsigned i = 1; i < halves; i++) begin
			tick_op = mdc22_pkg::OP_TICK;
			if (i == halves - 1) begin
				tick_op = tail_op;
			end else if (noisy && $urandom_range(19) == 0) begin
				tick_op = random_op();
			end
			push_beat(tick_op, 5'($urandom_range(31)), 5'($urandom_range(31)),
				16'($urandom_range(65535)), pick_din(din_mode));
		end
	endtask

	task automatic queue_random(int unsigned target);
		int unsigned stop_at;
		stop_at = queued_beats + target;
		while (queued_beats < stop_at) begin
			if ($urandom_range(99) < 85) begin
				queue_frame(random_start(), 5'($urandom_range(31)), 5'($urandom_range(31)),
					16'($urandom_range(65535)), DIN_RAND, ($urandom_range(3) == 0),
					($urandom_range(9) == 0) ? random_start() : mdc22_pkg::OP_TICK);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					push_beat(random_op(), 5'($urandom_range(31)), 5'($urandom_range(31)),
						16'($urandom_range(65535)), 1'($urandom_range(1)));
				end
			end
		end
	endtask

	function automatic bit all_drained();
		return pending_beats.size() == 0 && !req_ch.valid && expected_halves.size() == 0;
	endfunction

	// half periods still needed to finish the open frame
	function automatic int unsigned halves_left();
		int unsigned pre;
		int unsigned last_clk;
		int unsigned end_clk;
		pre = frm_read ? 32'(pre_rd) : 32'(pre_wr);
		last_clk = frm_read ? 32'(mdc22_pkg::RD_LAST_CLK) : 32'(mdc22_pkg::WR_LAST_CLK);
		end_clk = pre + last_clk;
		if (32'(clk_pos) >= end_clk) begin
			return hi_half ? 1 : 2;
		end
		return 2 * (end_clk - 32'(clk_pos)) + (hi_half ? 1 : 2);
	endfunction

	// close any open frame with plain ticks, then wait for every result beat
	task automatic close_phase();
		bit done;
		int unsigned left;
		done = 1'b0;
		while (!done) begin
			@(posedge clk);
			if (all_drained()) begin
				if (frm_active) begin
					left = halves_left();
					repeat (left) begin
						push_tick();
					end
				end else begin
					done = 1'b1;
				end
			end
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_preamble(mdc22_pkg::cfg_idx_t idx,
			logic [mdc22_pkg::PRE_W-1:0] value);
		logic [mdc22_pkg::PRE_W-1:0] held;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		held = (value > mdc22_pkg::PRE_MAX) ? mdc22_pkg::PRE_MAX : value;
		if (idx == mdc22_pkg::REG_WR_PRE) begin
			pre_wr = held;
		end else begin
			pre_rd = held;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = mdc22_pkg::REG_WR_PRE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		req_idle_pct = 30;
		rsp_stall_pct = 45;
		push_beat(mdc22_pkg::OP_TICK, 5'd0, 5'd0, 16'h0000, 1'b0);
		push_beat(mdc22_pkg::OP_TICK, 5'd31, 5'd31, 16'hFFFF, 1'b1);
		push_beat(mdc22_pkg::OP_RSVD, 5'd31, 5'd31, 16'hFFFF, 1'b1);
		queue_frame(mdc22_pkg::OP_WRITE, 5'd31, 5'd31, 16'hFFFF, DIN_ONE, 1'b1,
			mdc22_pkg::OP_READ);
		queue_frame(mdc22_pkg::OP_WRITE, 5'd0, 5'd0, 16'h0000, DIN_ZERO, 1'b0,
			mdc22_pkg::OP_TICK);
		queue_frame(mdc22_pkg::OP_READ, 5'd31, 5'd0, 16'hFFFF, DIN_ONE, 1'b0,
			mdc22_pkg::OP_WRITE);
		queue_frame(mdc22_pkg::OP_READ, 5'd0, 5'd31, 16'h0000, DIN_ZERO, 1'b0,
			mdc22_pkg::OP_TICK);
		queue_frame(mdc22_pkg::OP_READ, 5'd21, 5'd10, 16'hA5A5, DIN_RAND, 1'b1,
			mdc22_pkg::OP_TICK);
		push_beat(mdc22_pkg::OP_RSVD, 5'd0, 5'd0, 16'h0000, 1'b0);
		queue_random(120);
		close_phase();

		write_preamble(mdc22_pkg::REG_WR_PRE, 7'd5);
		write_preamble(mdc22_pkg::REG_RD_PRE, 7'd3);
		queue_random(150);
		close_phase();

		req_idle_pct = 45;
		rsp_stall_pct = 30;
		write_preamble(mdc22_pkg::REG_WR_PRE, 7'd0);
		write_preamble(mdc22_pkg::REG_RD_PRE, 7'd0);
		queue_random(150);
		close_phase();

		write_preamble(mdc22_pkg::REG_WR_PRE, 7'd127);
		write_preamble(mdc22_pkg::REG_RD_PRE, 7'd65);
		queue_random(150);
		close_phase();

		req_idle_pct = 0;
		rsp_stall_pct = 0;
		write_preamble(mdc22_pkg::REG_WR_PRE, 7'd64);
		write_preamble(mdc22_pkg::REG_RD_PRE, 7'd1);
		queue_random(150);
		close_phase();

		write_preamble(mdc22_pkg::REG_WR_PRE, 7'($urandom_range(127)));
		write_preamble(mdc22_pkg::REG_RD_PRE, 7'($urandom_range(127)));
		queue_random(150);
		close_phase();

		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: mdio_clause22_frame_master.f
+incdir+hdl
hdl/mdc22_pkg.sv
hdl/mdc22_if.sv
hdl/mdc22_cfg.sv
hdl/mdc22_core.sv
hdl/mdio_clause22_frame_master.sv
tb/sv/mdio_clause22_frame_master_tb.sv
